// ===== rtl/core/vra_pkg.sv =====
// Shared types, constants and the sine table generator for the axis rotator.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package vra_pkg;

  // Default number of address bits per quarter wave of the sine table.
  localparam int SINE_TABLE_ADDR_BITS_DEFAULT = 10;

  // Axis select codes.
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // Bit widths of the datapath.
  localparam int VEC_W   = 32;
  localparam int TRIG_W  = 16;
  localparam int MAG_W   = TRIG_W - 1;
  localparam int PROD_W  = VEC_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int FRAC_SH = 15;
  localparam int RND_W   = SUM_W - FRAC_SH;

  // Pi/2 in Q2.30 and the Taylor series denominators (2n)(2n+1).
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  // Request after the table lookup: table magnitudes as read, signs kept apart.
  typedef struct packed {
    logic                      bypass;
    logic [1:0]                func;
    logic signed [VEC_W-1:0]   x;
    logic signed [VEC_W-1:0]   y;
    logic signed [VEC_W-1:0]   z;
    logic [MAG_W-1:0]          sin_mag;
    logic [MAG_W-1:0]          cos_mag;
    logic                      sin_neg;
    logic                      cos_neg;
  } lookup_t;

  // Request after the multipliers.
  typedef struct packed {
    logic                      bypass;
    logic [1:0]                func;
    logic signed [VEC_W-1:0]   x;
    logic signed [VEC_W-1:0]   y;
    logic signed [VEC_W-1:0]   z;
    logic signed [PROD_W-1:0]  cu;
    logic signed [PROD_W-1:0]  sv;
    logic signed [PROD_W-1:0]  su;
    logic signed [PROD_W-1:0]  cv;
  } prod_t;

  // Request after the sums and rounding, before saturation.
  typedef struct packed {
    logic                      bypass;
    logic [1:0]                func;
    logic signed [VEC_W-1:0]   x;
    logic signed [VEC_W-1:0]   y;
    logic signed [VEC_W-1:0]   z;
    logic signed [RND_W-1:0]   first;
    logic signed [RND_W-1:0]   second;
  } sum_t;

  // One sine table entry, round(32768*sin(pi/2*k/N)) in unsigned Q0.15, capped at 32767.
  // Evaluated at elaboration only.
  function automatic logic [14:0] sine_entry(input int addr_bits, input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] r;
    longint      sum;
    x    = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if ((n & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (64'(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[14:0];
  endfunction

endpackage

// ===== rtl/core/vra_lookup.sv =====
// First pipeline stage: sine and cosine lookup from the quarter-wave table.
// Depends on vra_pkg for the request type, axis codes and table generator.
module vra_lookup #(
  parameter int SINE_TABLE_ADDR_BITS = vra_pkg::SINE_TABLE_ADDR_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      func,
  input  logic signed [15:0]              turn_angle,
  input  logic signed [vra_pkg::VEC_W-1:0] in_x,
  input  logic signed [vra_pkg::VEC_W-1:0] in_y,
  input  logic signed [vra_pkg::VEC_W-1:0] in_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vra_pkg::lookup_t                out_req
);

  localparam int AB      = SINE_TABLE_ADDR_BITS;
  localparam int TAB_TOP = 1 << AB;
  localparam logic [AB:0] TAB_N = {1'b1, {AB{1'b0}}};

  // Quarter-wave table, built at elaboration.
  logic [14:0] rom [0:TAB_TOP];

  for (genvar k = 0; k <= TAB_TOP; k++) begin : g_rom
    assign rom[k] = vra_pkg::sine_entry(AB, k);
  end

  logic [1:0]  quad_s;
  logic [1:0]  quad_c;
  logic [AB-1:0] idx_raw;
  logic [AB:0] idx_s;
  logic [AB:0] idx_c;
  vra_pkg::lookup_t req_next;
  vra_pkg::lookup_t stage;
  logic stage_valid;

  // Table index per quadrant; odd quadrants read mirrored. The table output goes
  // straight into the stage register, and the sign of the upper half travels with it.
  always_comb begin
    quad_s  = turn_angle[15:14];
    quad_c  = quad_s + 2'd1;
    idx_raw = turn_angle[13 -: AB];
    idx_s   = quad_s[0] ? (TAB_N - {1'b0, idx_raw}) : {1'b0, idx_raw};
    idx_c   = quad_c[0] ? (TAB_N - {1'b0, idx_raw}) : {1'b0, idx_raw};

    req_next.bypass  = (turn_angle == 16'sd0) || (func == vra_pkg::AXIS_NONE);
    req_next.func    = func;
    req_next.x       = in_x;
    req_next.y       = in_y;
    req_next.z       = in_z;
    req_next.sin_mag = rom[idx_s];
    req_next.cos_mag = rom[idx_c];
    req_next.sin_neg = quad_s[1];
    req_next.cos_neg = quad_c[1];
  end

  assign in_ready = !stage_valid || out_ready;

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= req_next;
    end
  end

  assign out_valid = stage_valid;
  assign out_req   = stage;

endmodule

// ===== rtl/core/vra_multiply.sv =====
// Second pipeline stage: signs of the table values, operand selection by axis
// and the four products. Depends on vra_pkg for the request types and axis codes.
module vra_multiply (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vra_pkg::lookup_t in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output vra_pkg::prod_t   out_req
);

  logic signed [vra_pkg::VEC_W-1:0] u;
  logic signed [vra_pkg::VEC_W-1:0] v;
  logic signed [vra_pkg::TRIG_W-1:0] sin_v;
  logic signed [vra_pkg::TRIG_W-1:0] cos_v;
  vra_pkg::prod_t req_next;
  vra_pkg::prod_t stage;
  logic stage_valid;

  // Every axis reduces to first = c*u - s*v and second = s*u + c*v.
  always_comb begin
    sin_v = in_req.sin_neg ? -$signed({1'b0, in_req.sin_mag})
                           : $signed({1'b0, in_req.sin_mag});
    cos_v = in_req.cos_neg ? -$signed({1'b0, in_req.cos_mag})
                           : $signed({1'b0, in_req.cos_mag});

    unique case (in_req.func)
      vra_pkg::AXIS_X: begin
        u = in_req.y;
        v = in_req.z;
      end
      vra_pkg::AXIS_Y: begin
        u = in_req.z;
        v = in_req.x;
      end
      vra_pkg::AXIS_Z: begin
        u = in_req.x;
        v = in_req.y;
      end
      default: begin
        u = in_req.x;
        v = in_req.y;
      end
    endcase

    req_next.bypass = in_req.bypass;
    req_next.func   = in_req.func;
    req_next.x      = in_req.x;
    req_next.y      = in_req.y;
    req_next.z      = in_req.z;
    req_next.cu     = vra_pkg::PROD_W'(cos_v) * vra_pkg::PROD_W'(u);
    req_next.sv     = vra_pkg::PROD_W'(sin_v) * vra_pkg::PROD_W'(v);
    req_next.su     = vra_pkg::PROD_W'(sin_v) * vra_pkg::PROD_W'(u);
    req_next.cv     = vra_pkg::PROD_W'(cos_v) * vra_pkg::PROD_W'(v);
  end

  assign in_ready = !stage_valid || out_ready;

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= req_next;
    end
  end

  assign out_valid = stage_valid;
  assign out_req   = stage;

endmodule

// ===== rtl/core/vra_accumulate.sv =====
// Third pipeline stage: sums of product pairs, rounded half up by 15 bits.
// Depends on vra_pkg for the request types and datapath widths.
module vra_accumulate (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  vra_pkg::prod_t in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output vra_pkg::sum_t  out_req
);

  localparam logic signed [vra_pkg::SUM_W-1:0] HALF_LSB =
    vra_pkg::SUM_W'(1 << (vra_pkg::FRAC_SH - 1));

  logic signed [vra_pkg::SUM_W-1:0] first_full;
  logic signed [vra_pkg::SUM_W-1:0] second_full;
  vra_pkg::sum_t req_next;
  vra_pkg::sum_t stage;
  logic stage_valid;

  // Exact sums plus half an output step; the shift then floors.
  always_comb begin
    first_full  = vra_pkg::SUM_W'(in_req.cu) - vra_pkg::SUM_W'(in_req.sv) + HALF_LSB;
    second_full = vra_pkg::SUM_W'(in_req.su) + vra_pkg::SUM_W'(in_req.cv) + HALF_LSB;

    req_next.bypass = in_req.bypass;
    req_next.func   = in_req.func;
    req_next.x      = in_req.x;
    req_next.y      = in_req.y;
    req_next.z      = in_req.z;
    req_next.first  = first_full[vra_pkg::SUM_W-1:vra_pkg::FRAC_SH];
    req_next.second = second_full[vra_pkg::SUM_W-1:vra_pkg::FRAC_SH];
  end

  assign in_ready = !stage_valid || out_ready;

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= req_next;
    end
  end

  assign out_valid = stage_valid;
  assign out_req   = stage;

endmodule

// ===== rtl/core/vra_output.sv =====
// Fourth pipeline stage: saturation and placement of the rotated components.
// Depends on vra_pkg for the request type, axis codes and widths.
module vra_output (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  vra_pkg::sum_t                    in_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [vra_pkg::VEC_W-1:0] out_x,
  output logic signed [vra_pkg::VEC_W-1:0] out_y,
  output logic signed [vra_pkg::VEC_W-1:0] out_z
);

  localparam int HI = vra_pkg::RND_W - 1;
  localparam int LO = vra_pkg::VEC_W - 1;

  logic signed [vra_pkg::VEC_W-1:0] first_sat;
  logic signed [vra_pkg::VEC_W-1:0] second_sat;
  logic signed [vra_pkg::VEC_W-1:0] x_next;
  logic signed [vra_pkg::VEC_W-1:0] y_next;
  logic signed [vra_pkg::VEC_W-1:0] z_next;
  logic signed [vra_pkg::VEC_W-1:0] x_reg;
  logic signed [vra_pkg::VEC_W-1:0] y_reg;
  logic signed [vra_pkg::VEC_W-1:0] z_reg;
  logic stage_valid;

  // Clamp a rounded sum to the 32-bit range.
  function automatic logic signed [vra_pkg::VEC_W-1:0] sat32(
    input logic signed [vra_pkg::RND_W-1:0] val
  );
    logic all_one;
    logic all_zero;
    all_one  = &val[HI:LO];
    all_zero = ~|val[HI:LO];
    if (all_one || all_zero) begin
      return val[vra_pkg::VEC_W-1:0];
    end else if (val[HI]) begin
      return {1'b1, {(vra_pkg::VEC_W-1){1'b0}}};
    end else begin
      return {1'b0, {(vra_pkg::VEC_W-1){1'b1}}};
    end
  endfunction

  // Put the two rotated components back on their axes.
  always_comb begin
    first_sat  = sat32(in_req.first);
    second_sat = sat32(in_req.second);
    x_next     = in_req.x;
    y_next     = in_req.y;
    z_next     = in_req.z;
    if (!in_req.bypass) begin
      unique case (in_req.func)
        vra_pkg::AXIS_X: begin
          y_next = first_sat;
          z_next = second_sat;
        end
        vra_pkg::AXIS_Y: begin
          z_next = first_sat;
          x_next = second_sat;
        end
        vra_pkg::AXIS_Z: begin
          x_next = first_sat;
          y_next = second_sat;
        end
        default: begin
          x_next = in_req.x;
        end
      endcase
    end
  end

  assign in_ready = !stage_valid || out_ready;

  // Valid bit of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      x_reg <= x_next;
      y_reg <= y_next;
      z_reg <= z_next;
    end
  end

  assign out_valid = stage_valid;
  assign out_x     = x_reg;
  assign out_y     = y_reg;
  assign out_z     = z_reg;

endmodule

// ===== rtl/core/vector_axis_rotate.sv =====
// A request accepted into the lookup register passes the multiply and accumulate
// registers in turn and reaches the output register, from which its result is taken.
// Throughput: one vector per cycle while out_ready is high; each of the four stages holds
// one request and moves on whenever the stage after it is empty or is being drained.
// Reset (rst, synchronous) empties every stage; no result is pending afterwards.
// Stages: table lookup, four 32x16 multipliers, rounded sums, saturation.
// Depends on vra_pkg and the vra_lookup, vra_multiply, vra_accumulate, vra_output stages.
module vector_axis_rotate #(
  parameter int SINE_TABLE_ADDR_BITS = vra_pkg::SINE_TABLE_ADDR_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       func,
  input  logic signed [15:0]               turn_angle,
  input  logic signed [vra_pkg::VEC_W-1:0] in_x,
  input  logic signed [vra_pkg::VEC_W-1:0] in_y,
  input  logic signed [vra_pkg::VEC_W-1:0] in_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [vra_pkg::VEC_W-1:0] out_x,
  output logic signed [vra_pkg::VEC_W-1:0] out_y,
  output logic signed [vra_pkg::VEC_W-1:0] out_z
);

  logic             lk_valid;
  logic             lk_ready;
  vra_pkg::lookup_t lk_req;
  logic             mul_valid;
  logic             mul_ready;
  vra_pkg::prod_t   mul_req;
  logic             acc_valid;
  logic             acc_ready;
  vra_pkg::sum_t    acc_req;

  // Sine and cosine lookup.
  vra_lookup #(
    .SINE_TABLE_ADDR_BITS(SINE_TABLE_ADDR_BITS)
  ) u_lookup (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .turn_angle (turn_angle),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .out_valid  (lk_valid),
    .out_ready  (lk_ready),
    .out_req    (lk_req)
  );

  // Products.
  vra_multiply u_multiply (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lk_valid),
    .in_ready  (lk_ready),
    .in_req    (lk_req),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_req   (mul_req)
  );

  // Rounded sums.
  vra_accumulate u_accumulate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_req    (mul_req),
    .out_valid (acc_valid),
    .out_ready (acc_ready),
    .out_req   (acc_req)
  );

  // Saturation and output register.
  vra_output u_output (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (acc_valid),
    .in_ready  (acc_ready),
    .in_req    (acc_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
  );

endmodule
